@@ rtl/key_matrix_press_filter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Key matrix press filter assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_PRESS_FILTER_UNIT_MACROS_SVH
`define KEY_MATRIX_PRESS_FILTER_UNIT_MACROS_SVH

// Same-cycle implication.
`define KMPF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KMPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kmpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Key matrix press filter package
// Field widths, register indexes, reset values and shared structs.
// ----------------------------------------------------------------------------
package kmpf_pkg;

  localparam int ROW_W      = 3;
  localparam int COL_W      = 4;
  localparam int TIME_W     = 32;
  localparam int DLY_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ROW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COL = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_ROW  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_COL  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_MUTED_ROW  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_MUTED_COL  = CFG_IDX_W'(7);

  localparam logic [DLY_W-1:0] DEBOUNCE_RST   = DLY_W'(300);
  localparam logic [DLY_W-1:0] REPEAT_RST     = DLY_W'(600);
  localparam logic [ROW_W-1:0] REPEAT_ROW_RST = ROW_W'(0);
  localparam logic [COL_W-1:0] REPEAT_COL_RST = COL_W'(0);
  localparam logic [ROW_W-1:0] GUARD_ROW_RST  = ROW_W'(2);
  localparam logic [COL_W-1:0] GUARD_COL_RST  = COL_W'(1);
  localparam logic [ROW_W-1:0] MUTED_ROW_RST  = ROW_W'(3);
  localparam logic [COL_W-1:0] MUTED_COL_RST  = COL_W'(1);

  typedef struct packed {
    logic [DLY_W-1:0] debounce_ms;
    logic [DLY_W-1:0] repeat_ms;
    logic [ROW_W-1:0] repeat_row;
    logic [COL_W-1:0] repeat_col;
    logic [ROW_W-1:0] guard_row;
    logic [COL_W-1:0] guard_col;
    logic [ROW_W-1:0] muted_row;
    logic [COL_W-1:0] muted_col;
  } kmpf_cfg_t;

  // Sample as held in the decision stage.
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              down;
    logic [TIME_W-1:0] now;
    logic              in_range;
    logic              mute_key;
    logic              rep_key;
  } kmpf_smp_t;

  // State update and result decided for one sample.
  typedef struct packed {
    logic emit;
    logic held_wr;
    logic held_val;
    logic stamp_wr;
  } kmpf_upd_t;

endpackage

@@ rtl/kmpf_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Key matrix press filter configuration registers
// Holds the timing windows and the repeat, guard and muted key positions.
// ----------------------------------------------------------------------------
module kmpf_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               wr_en_i,
  input  logic [kmpf_pkg::CFG_IDX_W-1:0]     wr_index_i,
  input  logic [kmpf_pkg::CFG_DATA_W-1:0]    wr_data_i,
  output kmpf_pkg::kmpf_cfg_t                cfg_o
);
  import kmpf_pkg::*;

  kmpf_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms <= DEBOUNCE_RST;
      cfg_q.repeat_ms   <= REPEAT_RST;
      cfg_q.repeat_row  <= REPEAT_ROW_RST;
      cfg_q.repeat_col  <= REPEAT_COL_RST;
      cfg_q.guard_row   <= GUARD_ROW_RST;
      cfg_q.guard_col   <= GUARD_COL_RST;
      cfg_q.muted_row   <= MUTED_ROW_RST;
      cfg_q.muted_col   <= MUTED_COL_RST;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CFG_DEBOUNCE:   cfg_q.debounce_ms <= wr_data_i[DLY_W-1:0];
        CFG_REPEAT:     cfg_q.repeat_ms   <= wr_data_i[DLY_W-1:0];
        CFG_REPEAT_ROW: cfg_q.repeat_row  <= wr_data_i[ROW_W-1:0];
        CFG_REPEAT_COL: cfg_q.repeat_col  <= wr_data_i[COL_W-1:0];
        CFG_GUARD_ROW:  cfg_q.guard_row   <= wr_data_i[ROW_W-1:0];
        CFG_GUARD_COL:  cfg_q.guard_col   <= wr_data_i[COL_W-1:0];
        CFG_MUTED_ROW:  cfg_q.muted_row   <= wr_data_i[ROW_W-1:0];
        CFG_MUTED_COL:  cfg_q.muted_col   <= wr_data_i[COL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/kmpf_stamp_mem.sv @@
// ----------------------------------------------------------------------------
// Key matrix press filter stamp memory
// One write port and two registered read ports, with per-entry valid bits
// so that unwritten entries read as zero, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module kmpf_stamp_mem #(
  parameter int DEPTH  = 55,
  parameter int ADDR_W = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [ADDR_W-1:0]               wr_addr_i,
  input  logic [kmpf_pkg::TIME_W-1:0]     wr_data_i,
  input  logic                            rd_en_i,
  input  logic [ADDR_W-1:0]               rd_a_addr_i,
  input  logic [ADDR_W-1:0]               rd_b_addr_i,
  output logic [kmpf_pkg::TIME_W-1:0]     rd_a_data_o,
  output logic [kmpf_pkg::TIME_W-1:0]     rd_b_data_o
);
  import kmpf_pkg::*;

  logic [TIME_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [TIME_W-1:0] rd_a_q;
  logic [TIME_W-1:0] rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // A read in the same cycle as a write to the same entry sees the new stamp.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_a_addr_i)) begin
        rd_a_q <= wr_data_i;
      end else if (!vld_q[rd_a_addr_i]) begin
        rd_a_q <= '0;
      end else begin
        rd_a_q <= mem_q[rd_a_addr_i];
      end
      if (wr_en_i && (wr_addr_i == rd_b_addr_i)) begin
        rd_b_q <= wr_data_i;
      end else if (!vld_q[rd_b_addr_i]) begin
        rd_b_q <= '0;
      end else begin
        rd_b_q <= mem_q[rd_b_addr_i];
      end
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

@@ rtl/kmpf_decide.sv @@
// ----------------------------------------------------------------------------
// Key matrix press filter decision logic
// Works out the report, held flag change and restamp for one key sample.
// ----------------------------------------------------------------------------
module kmpf_decide (
  input  kmpf_pkg::kmpf_smp_t              smp_i,
  input  logic                             held_i,
  input  logic [kmpf_pkg::TIME_W-1:0]      stamp_i,
  input  logic [kmpf_pkg::TIME_W-1:0]      guard_stamp_i,
  input  logic                             guard_ok_i,
  input  logic [kmpf_pkg::DLY_W-1:0]       debounce_ms_i,
  input  logic [kmpf_pkg::DLY_W-1:0]       repeat_ms_i,
  output kmpf_pkg::kmpf_upd_t              upd_o
);
  import kmpf_pkg::*;

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] guard_elapsed;
  logic [TIME_W-1:0] debounce_ext;
  logic [TIME_W-1:0] repeat_ext;
  logic              muted;

  assign elapsed       = smp_i.now - stamp_i;
  assign guard_elapsed = smp_i.now - guard_stamp_i;
  assign debounce_ext  = TIME_W'(debounce_ms_i);
  assign repeat_ext    = TIME_W'(repeat_ms_i);
  assign muted         = smp_i.mute_key && guard_ok_i && (guard_elapsed < debounce_ext);

  always_comb begin
    upd_o = '0;
    if (smp_i.in_range) begin
      if (!smp_i.down) begin
        if (elapsed > debounce_ext) begin
          upd_o.held_wr  = 1'b1;
          upd_o.held_val = 1'b0;
        end
      end else if (!held_i) begin
        upd_o.emit     = !muted;
        upd_o.held_wr  = 1'b1;
        upd_o.held_val = 1'b1;
        upd_o.stamp_wr = 1'b1;
      end else if (smp_i.rep_key && (elapsed > repeat_ext)) begin
        // Rearm: the next down sample reports the key again.
        upd_o.held_wr  = 1'b1;
        upd_o.held_val = 1'b0;
        upd_o.stamp_wr = 1'b1;
      end
    end
  end

endmodule

@@ rtl/key_matrix_press_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Key matrix press filter unit
// Debounce, guard muting and auto-repeat for scanned key matrix samples.
// ----------------------------------------------------------------------------
// Usage: the scan sequencer offers one key sample per request on the input
// channel (in_valid_i / in_stall_o); a key that goes down is reported as a
// row and column request on the output channel (out_valid_o / out_stall_i).
// Samples that release, hold, rearm or are muted give no output request.
// From input acceptance to out_valid_o: the key's stamp, the guard key's
// stamp and the held flag are captured in the decision stage when the
// sample is accepted, and the decision logic loads the output register when
// that stage passes the sample on. One sample is accepted per cycle while
// in_stall_o is low; the state written by one sample is forwarded to the
// next sample's read, so back-to-back samples of the same key are handled.
// When the receiver stalls with a result waiting, the decision stage holds
// its sample and in_stall_o rises until the output register is freed.
// Reset clears all held flags and stamp valid bits (stamps read as zero)
// and loads the register defaults. Configuration writes on cfg_valid_i are
// always taken (cfg_ready_o is high) and belong to idle periods.
// ----------------------------------------------------------------------------
module key_matrix_press_filter_unit #(
  parameter int ROWS = 5,
  parameter int COLS = 11
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [kmpf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kmpf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [kmpf_pkg::ROW_W-1:0]       scan_row_i,
  input  logic [kmpf_pkg::COL_W-1:0]       scan_col_i,
  input  logic                             key_down_i,
  input  logic [kmpf_pkg::TIME_W-1:0]      now_ms_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [kmpf_pkg::ROW_W-1:0]       press_row_o,
  output logic [kmpf_pkg::COL_W-1:0]       press_col_o
);
  import kmpf_pkg::*;

  localparam int NKEYS = ROWS * COLS;
  localparam int IDX_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  kmpf_cfg_t         cfg;
  kmpf_smp_t         smp_d;
  kmpf_smp_t         smp_q;
  kmpf_upd_t         upd;
  logic              s1_valid_q;
  logic [IDX_W-1:0]  s1_idx_q;
  logic [IDX_W-1:0]  key_idx;
  logic [IDX_W-1:0]  guard_idx;
  logic              in_range;
  logic              guard_ok;
  logic              in_accept;
  logic              out_free;
  logic              s1_fire;
  logic [NKEYS-1:0]  held_q;
  logic              held_rd_q;
  logic [TIME_W-1:0] stamp_rd;
  logic [TIME_W-1:0] guard_rd;
  logic              out_valid_q;
  logic [ROW_W-1:0]  press_row_q;
  logic [COL_W-1:0]  press_col_q;

  assign cfg_ready_o = 1'b1;

  kmpf_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Sample decode: range check and flat key index.
  assign in_range = (32'(scan_row_i) < 32'(ROWS)) && (32'(scan_col_i) < 32'(COLS));
  assign guard_ok = (32'(cfg.guard_row) < 32'(ROWS)) && (32'(cfg.guard_col) < 32'(COLS));
  assign key_idx  = in_range ?
                    IDX_W'(32'(scan_row_i) * 32'(COLS) + 32'(scan_col_i)) : '0;
  assign guard_idx = guard_ok ?
                     IDX_W'(32'(cfg.guard_row) * 32'(COLS) + 32'(cfg.guard_col)) : '0;

  always_comb begin
    smp_d.row      = scan_row_i;
    smp_d.col      = scan_col_i;
    smp_d.down     = key_down_i;
    smp_d.now      = now_ms_i;
    smp_d.in_range = in_range;
    smp_d.mute_key = (scan_row_i == cfg.muted_row) && (scan_col_i == cfg.muted_col);
    smp_d.rep_key  = (scan_row_i == cfg.repeat_row) && (scan_col_i == cfg.repeat_col);
  end

  // Handshake between the input, decision stage and output register.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      smp_q    <= smp_d;
      s1_idx_q <= key_idx;
      // A held flag written at this edge by the leaving sample is passed on.
      if (s1_fire && upd.held_wr && (s1_idx_q == key_idx)) begin
        held_rd_q <= upd.held_val;
      end else begin
        held_rd_q <= held_q[key_idx];
      end
    end
  end

  kmpf_stamp_mem #(
    .DEPTH  (NKEYS),
    .ADDR_W (IDX_W)
  ) u_stamp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (s1_fire && upd.stamp_wr),
    .wr_addr_i   (s1_idx_q),
    .wr_data_i   (smp_q.now),
    .rd_en_i     (in_accept),
    .rd_a_addr_i (key_idx),
    .rd_b_addr_i (guard_idx),
    .rd_a_data_o (stamp_rd),
    .rd_b_data_o (guard_rd)
  );

  kmpf_decide u_decide (
    .smp_i         (smp_q),
    .held_i        (held_rd_q),
    .stamp_i       (stamp_rd),
    .guard_stamp_i (guard_rd),
    .guard_ok_i    (guard_ok),
    .debounce_ms_i (cfg.debounce_ms),
    .repeat_ms_i   (cfg.repeat_ms),
    .upd_o         (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (s1_fire && upd.held_wr) begin
      held_q[s1_idx_q] <= upd.held_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && upd.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && upd.emit) begin
      press_row_q <= smp_q.row;
      press_col_q <= smp_q.col;
    end
  end

  assign out_valid_o = out_valid_q;
  assign press_row_o = press_row_q;
  assign press_col_o = press_col_q;

endmodule

@@ rtl/kmpf_checker.sv @@
// ----------------------------------------------------------------------------
// Key matrix press filter port checker
// Watches the top-level ports for output hold, stall cause and key range.
// ----------------------------------------------------------------------------
`include "key_matrix_press_filter_unit_macros.svh"

module kmpf_checker #(
  parameter int ROWS = 5,
  parameter int COLS = 11
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_i,
  input logic                        out_valid_i,
  input logic                        out_stall_i,
  input logic [kmpf_pkg::ROW_W-1:0]  press_row_i,
  input logic [kmpf_pkg::COL_W-1:0]  press_col_i
);
  import kmpf_pkg::*;

  `KMPF_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(press_row_i) && $stable(press_col_i), "stalled result changed")

  // The input side only backs up behind a stalled result.
  `KMPF_ASSERT_IMPL(a_stall_cause, in_stall_i, out_valid_i && out_stall_i, "input stalled without a stalled result")

  `KMPF_ASSERT_IMPL(a_key_range, out_valid_i, (32'(press_row_i) < 32'(ROWS)) && (32'(press_col_i) < 32'(COLS)), "reported key outside the matrix")

endmodule

bind key_matrix_press_filter_unit kmpf_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_kmpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .press_row_i (press_row_o),
  .press_col_i (press_col_o)
);
